/* hdl/rgb_to_hsv_pixel_defines.svh */
// Assertion macros for the RGB to HSV pixel converter
`ifndef RGB_TO_HSV_PIXEL_DEFINES_SVH
`define RGB_TO_HSV_PIXEL_DEFINES_SVH

// Base check, clocked on clk and off during reset
`define RHP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define RHP_ASSERT_IMP(label, ante, cons, msg) \
  `RHP_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication
`define RHP_ASSERT_NXT(label, ante, cons, msg) \
  `RHP_ASSERT(label, (ante) |=> (cons), msg)

`endif

/* hdl/rgbhsv_pkg.sv */
// Types and constants for the RGB to HSV pixel converter
`timescale 1ns / 1ps
package rgbhsv_pkg;

  localparam int FIELD_W    = 16;
  localparam int CHAN_BITS  = 16;
  localparam int Q_BITS     = 16;
  localparam int HDEN_W     = CHAN_BITS + 3;
  localparam int SPROD_W    = CHAN_BITS + Q_BITS;
  localparam int TDATA_W    = 4 * FIELD_W;
  localparam int NUM_STAGES = Q_BITS + 3;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // Fields that ride along with a pixel through the whole pipeline
  typedef struct packed {
    logic                 byp;
    logic [FIELD_W-1:0]   red;
    logic [FIELD_W-1:0]   green;
    logic [FIELD_W-1:0]   blue;
    logic [FIELD_W-1:0]   alpha;
    logic [CHAN_BITS-1:0] value;
  } pass_t;

  typedef struct packed {
    pass_t                pass;
    sector_t              sector;
    logic [CHAN_BITS-1:0] r;
    logic [CHAN_BITS-1:0] g;
    logic [CHAN_BITS-1:0] b;
    logic [CHAN_BITS-1:0] lo;
  } front_t;

  typedef struct packed {
    pass_t                pass;
    logic [HDEN_W-1:0]    h_rem;
    logic [HDEN_W-1:0]    h_den;
    logic [Q_BITS-1:0]    h_quo;
    logic [CHAN_BITS-1:0] s_rem;
    logic [CHAN_BITS-1:0] s_den;
    logic [Q_BITS-1:0]    s_low;
    logic [Q_BITS-1:0]    s_quo;
  } divst_t;

endpackage

/* hdl/rgb_to_hsv_pixel.sv */
// RGB to HSV pixel converter, pipelined, one pixel per clock unless out_tready stalls
// One pixel per clock unless out_tready stalls; each pixel passes in order through: one
// stage finds max, min and the hue sector, one forms the hue and saturation dividends and
// divisors, sixteen restoring-divider stages each retire one quotient bit of both hue and
// saturation, and the output register drives out_tdata. Bubbles collapse and a stalled
// output only holds the stages that are full. With bypass set, red, green and blue come
// out unchanged in place of hue, saturation and value; alpha always passes through.
`timescale 1ns / 1ps
`include "rgb_to_hsv_pixel_defines.svh"
module rgb_to_hsv_pixel (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // red_in, green_in, blue_in, alpha_in (16 bits each, from bit 0 up)
  input  logic [rgbhsv_pkg::TDATA_W-1:0] in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // hue_or_red, sat_or_green, value_or_blue, alpha_out (16 bits each, from bit 0 up)
  output logic [rgbhsv_pkg::TDATA_W-1:0] out_tdata
);
  import rgbhsv_pkg::*;

  logic                  bypass_r;
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] adv;
  front_t                s1_r;
  front_t                s1_nxt;
  divst_t                dv_r   [0:Q_BITS];
  divst_t                dv0_nxt;
  divst_t                dv_nxt [1:Q_BITS];
  logic [TDATA_W-1:0]    out_data_r;
  logic [TDATA_W-1:0]    out_nxt;
  logic                  out_byp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r <= 1'b0;
    end else if (cfg_wr_en) begin
      bypass_r <= cfg_wr_data;
    end
  end

  // A stage advances when it is empty or the stage after it advances
  always_comb begin
    adv[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_tready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign in_tready  = adv[0];
  assign out_tvalid = vld_r[NUM_STAGES-1];
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // Front stage: max, min and hue sector (ties go red, then green)
  always_comb begin
    logic [CHAN_BITS-1:0] r;
    logic [CHAN_BITS-1:0] g;
    logic [CHAN_BITS-1:0] b;
    r = CHAN_BITS'(in_tdata[FIELD_W-1:0]);
    g = CHAN_BITS'(in_tdata[2*FIELD_W-1:FIELD_W]);
    b = CHAN_BITS'(in_tdata[3*FIELD_W-1:2*FIELD_W]);
    s1_nxt.pass.byp   = bypass_r;
    s1_nxt.pass.red   = in_tdata[FIELD_W-1:0];
    s1_nxt.pass.green = in_tdata[2*FIELD_W-1:FIELD_W];
    s1_nxt.pass.blue  = in_tdata[3*FIELD_W-1:2*FIELD_W];
    s1_nxt.pass.alpha = in_tdata[4*FIELD_W-1:3*FIELD_W];
    s1_nxt.r = r;
    s1_nxt.g = g;
    s1_nxt.b = b;
    if (r >= g && r >= b) begin
      s1_nxt.sector     = SEC_RED;
      s1_nxt.pass.value = r;
    end else if (g >= b) begin
      s1_nxt.sector     = SEC_GREEN;
      s1_nxt.pass.value = g;
    end else begin
      s1_nxt.sector     = SEC_BLUE;
      s1_nxt.pass.value = b;
    end
    if (r <= g && r <= b) begin
      s1_nxt.lo = r;
    end else if (g <= b) begin
      s1_nxt.lo = g;
    end else begin
      s1_nxt.lo = b;
    end
  end

  // Setup stage: dividends and divisors; grey and black pixels divide hue zero by one, black ones saturation too
  always_comb begin
    logic [CHAN_BITS-1:0] diff;
    logic [HDEN_W-1:0]    d1;
    logic [HDEN_W-1:0]    d6;
    logic [HDEN_W-1:0]    num;
    logic [SPROD_W-1:0]   prod;
    diff = s1_r.pass.value - s1_r.lo;
    d1   = HDEN_W'(diff);
    d6   = (d1 << 2) + (d1 << 1);
    case (s1_r.sector)
      SEC_RED: begin
        num = HDEN_W'(s1_r.g) - HDEN_W'(s1_r.b) + ((s1_r.g < s1_r.b) ? d6 : '0);
      end
      SEC_GREEN: begin
        num = HDEN_W'(s1_r.b) - HDEN_W'(s1_r.r) + (d1 << 1);
      end
      SEC_BLUE: begin
        num = HDEN_W'(s1_r.r) - HDEN_W'(s1_r.g) + (d1 << 2);
      end
      default: begin
        num = '0;
      end
    endcase
    // diff * 65535 as a shift and subtract
    prod = (SPROD_W'(diff) << Q_BITS) - SPROD_W'(diff);
    dv0_nxt.pass  = s1_r.pass;
    dv0_nxt.h_rem = (diff == '0) ? '0 : num;
    dv0_nxt.h_den = (diff == '0) ? HDEN_W'(1) : d6;
    dv0_nxt.h_quo = '0;
    dv0_nxt.s_rem = prod[SPROD_W-1 -: CHAN_BITS];
    dv0_nxt.s_low = prod[Q_BITS-1:0];
    dv0_nxt.s_den = (s1_r.pass.value == '0) ? CHAN_BITS'(1) : s1_r.pass.value;
    dv0_nxt.s_quo = '0;
  end

  // Divider stages: one quotient bit of hue and of saturation each
  always_comb begin
    logic [HDEN_W:0]    h_sh;
    logic [CHAN_BITS:0] s_sh;
    for (int k = 1; k <= Q_BITS; k++) begin
      dv_nxt[k] = dv_r[k-1];
      h_sh = {dv_r[k-1].h_rem, 1'b0};
      if (h_sh >= {1'b0, dv_r[k-1].h_den}) begin
        dv_nxt[k].h_rem = HDEN_W'(h_sh - {1'b0, dv_r[k-1].h_den});
        dv_nxt[k].h_quo = {dv_r[k-1].h_quo[Q_BITS-2:0], 1'b1};
      end else begin
        dv_nxt[k].h_rem = h_sh[HDEN_W-1:0];
        dv_nxt[k].h_quo = {dv_r[k-1].h_quo[Q_BITS-2:0], 1'b0};
      end
      s_sh = {dv_r[k-1].s_rem, dv_r[k-1].s_low[Q_BITS-1]};
      dv_nxt[k].s_low = {dv_r[k-1].s_low[Q_BITS-2:0], 1'b0};
      if (s_sh >= {1'b0, dv_r[k-1].s_den}) begin
        dv_nxt[k].s_rem = CHAN_BITS'(s_sh - {1'b0, dv_r[k-1].s_den});
        dv_nxt[k].s_quo = {dv_r[k-1].s_quo[Q_BITS-2:0], 1'b1};
      end else begin
        dv_nxt[k].s_rem = s_sh[CHAN_BITS-1:0];
        dv_nxt[k].s_quo = {dv_r[k-1].s_quo[Q_BITS-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (dv_r[Q_BITS].pass.byp) begin
      out_nxt = {dv_r[Q_BITS].pass.alpha, dv_r[Q_BITS].pass.blue,
                 dv_r[Q_BITS].pass.green, dv_r[Q_BITS].pass.red};
    end else begin
      out_nxt = {dv_r[Q_BITS].pass.alpha, FIELD_W'(dv_r[Q_BITS].pass.value),
                 FIELD_W'(dv_r[Q_BITS].s_quo), FIELD_W'(dv_r[Q_BITS].h_quo)};
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_r <= s1_nxt;
    end
    if (adv[1]) begin
      dv_r[0] <= dv0_nxt;
    end
    for (int i = 1; i <= Q_BITS; i++) begin
      if (adv[i+1]) begin
        dv_r[i] <= dv_nxt[i];
      end
    end
    if (adv[NUM_STAGES-1]) begin
      out_data_r <= out_nxt;
      out_byp_r  <= dv_r[Q_BITS].pass.byp;
    end
  end

  `RHP_ASSERT_NXT(a_accept_fills_front, in_tvalid && in_tready, vld_r[0],
                  "accepted transaction did not enter front stage")
  `RHP_ASSERT_IMP(a_grey_hue_zero,
                  out_tvalid && !out_byp_r && out_tdata[2*FIELD_W-1:FIELD_W] == '0,
                  out_tdata[FIELD_W-1:0] == '0, "zero saturation with nonzero hue")
  `RHP_ASSERT_IMP(a_black_sat_zero,
                  out_tvalid && !out_byp_r && out_tdata[3*FIELD_W-1:2*FIELD_W] == '0,
                  out_tdata[2*FIELD_W-1:FIELD_W] == '0, "black pixel with nonzero saturation")

endmodule
